// ===== sv/rrec_pkg.sv =====
// ----------------------------------------------------------------------------
// rrec_pkg
// Shared constants, the quarter-wave sine table and its lookup functions
// for the rotated rectangle edge crossing pipeline.
// ----------------------------------------------------------------------------
package rrec_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int TOL_BITS       = 8;
    localparam int ANGLE_BITS     = 9;
    localparam int TRIG_BITS      = 16;

    // round(sin(k deg) * 2^14), k = 0..90
    localparam logic [14:0] SINE_Q14 [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,
        15'd1713,  15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,
        15'd3406,  15'd3686,  15'd3964,  15'd4240,  15'd4516,  15'd4790,
        15'd5063,  15'd5334,  15'd5604,  15'd5872,  15'd6138,  15'd6402,
        15'd6664,  15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
        15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,  15'd9397,
        15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
        15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982,
        15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085,
        15'd13255, 15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849,
        15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491,
        15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
        15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
        15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    function automatic logic signed [TRIG_BITS-1:0] sine_deg(input logic [ANGLE_BITS-1:0] d);
        logic [ANGLE_BITS-1:0] a;
        logic [ANGLE_BITS-1:0] r;
        logic [1:0]            q;
        logic [14:0]           v;
        a = (d >= 9'd360) ? d - 9'd360 : d;
        if (a < 9'd90)       begin q = 2'd0; r = a;          end
        else if (a < 9'd180) begin q = 2'd1; r = a - 9'd90;  end
        else if (a < 9'd270) begin q = 2'd2; r = a - 9'd180; end
        else                 begin q = 2'd3; r = a - 9'd270; end
        if (q[0]) v = SINE_Q14[7'(9'd90 - r)];
        else      v = SINE_Q14[7'(r)];
        sine_deg = q[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    function automatic logic [ANGLE_BITS-1:0] cos_angle(input logic [ANGLE_BITS-1:0] d);
        logic [ANGLE_BITS-1:0] a;
        a = (d >= 9'd360) ? d - 9'd360 : d;
        cos_angle = (a >= 9'd270) ? a - 9'd270 : a + 9'd90;
    endfunction

endpackage

// ===== sv/rrec_corners.sv =====
// ----------------------------------------------------------------------------
// rrec_corners
// Two-stage corner generator: trig lookup and products, then corner sums.
// ----------------------------------------------------------------------------
module rrec_corners #(
    parameter int COORD_BITS = rrec_pkg::COORD_BITS_DEF,
    parameter int PT_BITS    = COORD_BITS + 18
) (
    input  logic                                  clk,
    input  logic                                  adv,
    input  logic signed [COORD_BITS-1:0]          cx,
    input  logic signed [COORD_BITS-1:0]          cy,
    input  logic        [COORD_BITS-1:0]          w,
    input  logic        [COORD_BITS-1:0]          h,
    input  logic        [rrec_pkg::ANGLE_BITS-1:0] ang,
    output logic signed [PT_BITS-1:0]             px [4],
    output logic signed [PT_BITS-1:0]             py [4]
);
    import rrec_pkg::*;

    localparam int PB = COORD_BITS + TRIG_BITS + 1;

    logic signed [PB-1:0] wc_reg, ws_reg, hc_reg, hs_reg;
    logic signed [PT_BITS-1:0] cx_reg, cy_reg;
    logic signed [TRIG_BITS-1:0] s, c;

    assign s = sine_deg(ang);
    assign c = sine_deg(cos_angle(ang));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wc_reg <= $signed({1'b0, w}) * c;
            ws_reg <= $signed({1'b0, w}) * s;
            hc_reg <= $signed({1'b0, h}) * c;
            hs_reg <= $signed({1'b0, h}) * s;
            cx_reg <= PT_BITS'(cx) <<< 15;
            cy_reg <= PT_BITS'(cy) <<< 15;
        end
    end

    logic signed [PT_BITS-1:0] wc, ws, hc, hs;
    assign wc = PT_BITS'(wc_reg);
    assign ws = PT_BITS'(ws_reg);
    assign hc = PT_BITS'(hc_reg);
    assign hs = PT_BITS'(hs_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px[0] <= cx_reg - wc + hs; py[0] <= cy_reg - ws - hc;
            px[1] <= cx_reg + wc + hs; py[1] <= cy_reg + ws - hc;
            px[2] <= cx_reg + wc - hs; py[2] <= cy_reg + ws + hc;
            px[3] <= cx_reg - wc - hs; py[3] <= cy_reg - ws + hc;
        end
    end
endmodule

// ===== sv/rrec_orient.sv =====
// ----------------------------------------------------------------------------
// rrec_orient
// Three-stage orientation sign: differences, products, compare.
// ----------------------------------------------------------------------------
module rrec_orient #(
    parameter int PT_BITS = rrec_pkg::COORD_BITS_DEF + 18
) (
    input  logic                              clk,
    input  logic                              adv,
    input  logic signed [PT_BITS-1:0]         p_x, p_y, q_x, q_y, r_x, r_y,
    input  logic [rrec_pkg::TOL_BITS-1:0]     tol,
    output logic [1:0]                        sgn
);
    import rrec_pkg::*;

    localparam int DB = PT_BITS + 1;
    localparam int MB = 2 * DB;

    logic signed [DB-1:0] d0_reg, d1_reg, d2_reg, d3_reg;
    logic signed [MB-1:0] a_reg, b_reg;
    logic signed [MB:0]   diff;
    logic [MB:0]          mag, thr;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d0_reg <= DB'(q_x) - DB'(p_x);
            d1_reg <= DB'(r_y) - DB'(p_y);
            d2_reg <= DB'(q_y) - DB'(p_y);
            d3_reg <= DB'(r_x) - DB'(p_x);
            a_reg  <= d0_reg * d1_reg;
            b_reg  <= d2_reg * d3_reg;
        end
    end

    assign diff = (MB+1)'(a_reg) - (MB+1)'(b_reg);
    assign mag  = diff[MB] ? (MB+1)'(-diff) : (MB+1)'(diff);
    assign thr  = (MB+1)'(tol) << 30;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (mag <= thr) sgn <= 2'b00;
            else            sgn <= diff[MB] ? 2'b11 : 2'b01;
        end
    end
endmodule

// ===== sv/rotated_rect_edge_crossing.sv =====
// ----------------------------------------------------------------------------
// rotated_rect_edge_crossing
// Tests two rotated rectangles for a proper crossing of any edge pair.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: ten rectangle fields with in_valid / in_stall. A request
//   is taken when in_valid is high and in_stall is low.
//   Output channel: edges_cross with out_valid / out_stall.
//   Config channel: cfg_valid / cfg_ready / cfg_data writes the collinear
//   tolerance; cfg_ready is always high.
//   Throughput: one request per cycle while the output is not stalled.
//   Pipeline: 2 corner stages, 3 orientation stages, sign combine
//   into the output register.
//   The whole pipeline advances together; while out_stall holds a full
//   output register, every stage holds and in_stall is raised.
//   Reset clears all valid bits and sets the tolerance to zero.
// ----------------------------------------------------------------------------
module rotated_rect_edge_crossing #(
    parameter int COORD_BITS = rrec_pkg::COORD_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [COORD_BITS-1:0]           first_center_x,
    input  logic signed [COORD_BITS-1:0]           first_center_y,
    input  logic        [COORD_BITS-1:0]           first_width,
    input  logic        [COORD_BITS-1:0]           first_height,
    input  logic        [rrec_pkg::ANGLE_BITS-1:0] first_angle,
    input  logic signed [COORD_BITS-1:0]           second_center_x,
    input  logic signed [COORD_BITS-1:0]           second_center_y,
    input  logic        [COORD_BITS-1:0]           second_width,
    input  logic        [COORD_BITS-1:0]           second_height,
    input  logic        [rrec_pkg::ANGLE_BITS-1:0] second_angle,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   edges_cross,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [rrec_pkg::TOL_BITS-1:0]   cfg_data
);
    import rrec_pkg::*;

    localparam int PT_BITS = COORD_BITS + 18;
    localparam int DEPTH   = 5;

    logic                 adv;
    logic [DEPTH-1:0]     vld_reg;
    logic [TOL_BITS-1:0]  tol_reg;
    logic                 out_valid_reg, edges_cross_reg;
    logic signed [PT_BITS-1:0] ax [4], ay [4], bx [4], by [4];
    logic [1:0]           o [16][4];
    logic                 hit;

    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;
    assign out_valid   = out_valid_reg;
    assign edges_cross = edges_cross_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg       <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid) tol_reg <= cfg_data;
            if (adv)
            begin
                vld_reg       <= {vld_reg[DEPTH-2:0], in_valid};
                out_valid_reg <= vld_reg[DEPTH-1];
            end
        end
    end

    rrec_corners #(.COORD_BITS(COORD_BITS), .PT_BITS(PT_BITS)) u_ca (
        .clk(clk), .adv(adv),
        .cx(first_center_x), .cy(first_center_y), .w(first_width),
        .h(first_height), .ang(first_angle), .px(ax), .py(ay)
    );

    rrec_corners #(.COORD_BITS(COORD_BITS), .PT_BITS(PT_BITS)) u_cb (
        .clk(clk), .adv(adv),
        .cx(second_center_x), .cy(second_center_y), .w(second_width),
        .h(second_height), .ang(second_angle), .px(bx), .py(by)
    );

    for (genvar i = 0; i < 4; i++)
    begin : g_i
        for (genvar j = 0; j < 4; j++)
        begin : g_j
            localparam int I2 = (i + 1) % 4;
            localparam int J2 = (j + 1) % 4;
            rrec_orient #(.PT_BITS(PT_BITS)) u_o1 (.clk(clk), .adv(adv),
                .p_x(ax[i]), .p_y(ay[i]), .q_x(ax[I2]), .q_y(ay[I2]),
                .r_x(bx[j]), .r_y(by[j]), .tol(tol_reg), .sgn(o[i*4+j][0]));
            rrec_orient #(.PT_BITS(PT_BITS)) u_o2 (.clk(clk), .adv(adv),
                .p_x(ax[i]), .p_y(ay[i]), .q_x(ax[I2]), .q_y(ay[I2]),
                .r_x(bx[J2]), .r_y(by[J2]), .tol(tol_reg), .sgn(o[i*4+j][1]));
            rrec_orient #(.PT_BITS(PT_BITS)) u_o3 (.clk(clk), .adv(adv),
                .p_x(bx[j]), .p_y(by[j]), .q_x(bx[J2]), .q_y(by[J2]),
                .r_x(ax[i]), .r_y(ay[i]), .tol(tol_reg), .sgn(o[i*4+j][2]));
            rrec_orient #(.PT_BITS(PT_BITS)) u_o4 (.clk(clk), .adv(adv),
                .p_x(bx[j]), .p_y(by[j]), .q_x(bx[J2]), .q_y(by[J2]),
                .r_x(ax[I2]), .r_y(ay[I2]), .tol(tol_reg), .sgn(o[i*4+j][3]));
        end
    end

    // opposite nonzero signs: both nonzero and sign bits differ
    always_comb
    begin
        hit = 1'b0;
        for (int k = 0; k < 16; k++)
        begin
            if (o[k][0][0] && o[k][1][0] && (o[k][0][1] != o[k][1][1]) &&
                o[k][2][0] && o[k][3][0] && (o[k][2][1] != o[k][3][1]))
                hit = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) edges_cross_reg <= hit;
    end
endmodule

// ===== sv/rrec_checker.sv =====
// ----------------------------------------------------------------------------
// rrec_checker
// Port-level checks for the rotated rectangle edge crossing block.
// ----------------------------------------------------------------------------
module rrec_checker (
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic edges_cross,
    input logic cfg_ready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(edges_cross))
        else $error("result changed under stall");

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

    a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config not ready");
endmodule

bind rotated_rect_edge_crossing rrec_checker u_rrec_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .edges_cross(edges_cross),
    .cfg_ready(cfg_ready)
);

// ===== bench/rotated_rect_edge_crossing_test.sv =====
// ----------------------------------------------------------------------------
// rotated_rect_edge_crossing_test
// Self-checking bench for the rotated rectangle edge crossing pipeline. A
// directed table and constrained-by-hand random rectangle pairs are pushed
// through the request channel with random gaps and output stalls. Each
// accepted request is scored by a typed result or an in-bench fixed-point
// crossing predictor under several collinear tolerance settings.
// ----------------------------------------------------------------------------
module rotated_rect_edge_crossing_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rrec_pkg::*;

    localparam int  CB          = COORD_BITS_DEF;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  DRAIN       = 20;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef struct {
        logic signed [CB-1:0]         cx;
        logic signed [CB-1:0]         cy;
        logic        [CB-1:0]         w;
        logic        [CB-1:0]         h;
        logic        [ANGLE_BITS-1:0] ang;
    } rect_t;

    typedef struct {
        rect_t      a;
        rect_t      b;
        int         known;   // -1: use predictor
    } pair_row_t;

    typedef struct {
        longint x;
        longint y;
    } corner_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [CB-1:0]         first_center_x;
    logic signed [CB-1:0]         first_center_y;
    logic        [CB-1:0]         first_width;
    logic        [CB-1:0]         first_height;
    logic        [ANGLE_BITS-1:0] first_angle;
    logic signed [CB-1:0]         second_center_x;
    logic signed [CB-1:0]         second_center_y;
    logic        [CB-1:0]         second_width;
    logic        [CB-1:0]         second_height;
    logic        [ANGLE_BITS-1:0] second_angle;
    logic                         out_valid;
    logic                         out_stall;
    logic                         edges_cross;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic        [TOL_BITS-1:0]   cfg_data;

    rotated_rect_edge_crossing #(.COORD_BITS(CB)) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .first_center_x  (first_center_x),
        .first_center_y  (first_center_y),
        .first_width     (first_width),
        .first_height    (first_height),
        .first_angle     (first_angle),
        .second_center_x (second_center_x),
        .second_center_y (second_center_y),
        .second_width    (second_width),
        .second_height   (second_height),
        .second_angle    (second_angle),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .edges_cross     (edges_cross),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    logic [TOL_BITS-1:0] tolerance;
    longint              sine_q14 [0:90];
    logic                crossing_q [$];
    int                  errors;
    int                  n_req;
    int                  n_hits;
    int                  n_results;
    int                  cycles;
    int                  stall_mode;
    bit                  gaps_on;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // quarter-wave sine, Q30 Taylor series rounded to Q14
    function automatic longint quarter_sine(int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          r;
        x    = (longint'(k) * PI_Q30 + 90) / 180;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (sum + 32768) >>> 16;
        if (r > 16384)
            r = 16384;
        return r;
    endfunction

    function automatic longint sine_of(int unsigned d);
        int unsigned q;
        int unsigned r;
        q = (d / 90) % 4;
        r = d % 90;
        case (q)
            0: return sine_q14[r];
            1: return sine_q14[90 - r];
            2: return -sine_q14[r];
            default: return -sine_q14[90 - r];
        endcase
    endfunction

    function automatic void rect_corners(rect_t rc, output corner_t c [4]);
        longint      cx;
        longint      cy;
        longint      w;
        longint      h;
        longint      s;
        longint      co;
        int unsigned a;
        cx = longint'(rc.cx) * 32768;
        cy = longint'(rc.cy) * 32768;
        w  = longint'({1'b0, rc.w});
        h  = longint'({1'b0, rc.h});
        a  = rc.ang;
        if (a >= 360)
            a = a - 360;
        s  = sine_of(a);
        co = sine_of((a + 90) % 360);
        c[0].x = cx - w * co + h * s;  c[0].y = cy - w * s - h * co;
        c[1].x = cx + w * co + h * s;  c[1].y = cy + w * s - h * co;
        c[2].x = cx + w * co - h * s;  c[2].y = cy + w * s + h * co;
        c[3].x = cx - w * co - h * s;  c[3].y = cy - w * s + h * co;
    endfunction

    function automatic int side_of(corner_t p, corner_t q, corner_t r);
        logic signed [127:0] ax;
        logic signed [127:0] ay;
        logic signed [127:0] bx;
        logic signed [127:0] by;
        logic signed [127:0] d;
        logic signed [127:0] lim;
        ax  = q.x - p.x;
        ay  = r.y - p.y;
        bx  = q.y - p.y;
        by  = r.x - p.x;
        d   = ax * ay - bx * by;
        lim = 128'(tolerance) << 30;
        if ((d < 0 ? -d : d) <= lim)
            return 0;
        return (d < 0) ? -1 : 1;
    endfunction

    function automatic logic predict_crossing(rect_t ra, rect_t rb);
        corner_t ca [4];
        corner_t cb [4];
        int      o1;
        int      o2;
        int      o3;
        int      o4;
        rect_corners(ra, ca);
        rect_corners(rb, cb);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
            begin
                o1 = side_of(ca[i], ca[(i + 1) % 4], cb[j]);
                o2 = side_of(ca[i], ca[(i + 1) % 4], cb[(j + 1) % 4]);
                o3 = side_of(cb[j], cb[(j + 1) % 4], ca[i]);
                o4 = side_of(cb[j], cb[(j + 1) % 4], ca[(i + 1) % 4]);
                if (o1 * o2 < 0 && o3 * o4 < 0)
                    return 1'b1;
            end
        return 1'b0;
    endfunction

    function automatic rect_t mk_rect(int cx, int cy, int w, int h, int ang);
        rect_t r;
        r.cx  = CB'(cx);
        r.cy  = CB'(cy);
        r.w   = CB'(w);
        r.h   = CB'(h);
        r.ang = ANGLE_BITS'(ang);
        return r;
    endfunction

    function automatic int short_gap();
        int p;
        p = $urandom_range(0, 99);
        if (!gaps_on || p < 65)
            return 0;
        if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // one request: optional gap, drive, hold until taken
    task automatic send_pair(rect_t ra, rect_t rb, int known);
        int   g;
        logic exp_bit;
        g = short_gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid        <= 1'b1;
        first_center_x  <= ra.cx;
        first_center_y  <= ra.cy;
        first_width     <= ra.w;
        first_height    <= ra.h;
        first_angle     <= ra.ang;
        second_center_x <= rb.cx;
        second_center_y <= rb.cy;
        second_width    <= rb.w;
        second_height   <= rb.h;
        second_angle    <= rb.ang;
        do @(posedge clk); while (in_stall);
        exp_bit = (known >= 0) ? logic'(known) : predict_crossing(ra, rb);
        crossing_q = {crossing_q, exp_bit};
        n_req++;
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (crossing_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [TOL_BITS-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        tolerance = v;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic rect_t rand_rect();
        rect_t r;
        r.cx  = CB'($urandom);
        r.cy  = CB'($urandom);
        r.w   = CB'($urandom);
        r.h   = CB'($urandom);
        r.ang = ANGLE_BITS'($urandom);
        return r;
    endfunction

    function automatic rect_t near_rect(rect_t base, int spread);
        rect_t r;
        r.cx  = CB'(int'(base.cx) + $urandom_range(0, 2 * spread) - spread);
        r.cy  = CB'(int'(base.cy) + $urandom_range(0, 2 * spread) - spread);
        r.w   = ($urandom_range(0, 19) == 0) ? '0 : CB'($urandom_range(1, 900));
        r.h   = ($urandom_range(0, 19) == 0) ? '0 : CB'($urandom_range(1, 900));
        r.ang = ($urandom_range(0, 3) == 0) ? ANGLE_BITS'($urandom_range(0, 511))
                                            : ANGLE_BITS'($urandom_range(0, 359));
        return r;
    endfunction

    task automatic random_pairs(int n);
        rect_t ra;
        rect_t rb;
        int    p;
        for (int i = 0; i < n; i++)
        begin
            p = $urandom_range(0, 99);
            if (p < 70)
            begin
                ra = near_rect(mk_rect($urandom_range(0, 60000) - 30000,
                                       $urandom_range(0, 60000) - 30000, 0, 0, 0), 0);
                rb = near_rect(ra, 1500);
            end
            else if (p < 85)
            begin
                ra = rand_rect();
                rb = rand_rect();
            end
            else
            begin
                // huge sizes near the coordinate limits
                ra = rand_rect();
                rb = near_rect(ra, 4000);
                rb.w = CB'($urandom_range(30000, 65535));
                ra.h = CB'($urandom_range(30000, 65535));
            end
            if (i % 150 == 0)
                gaps_on = ~gaps_on;
            send_pair(ra, rb, -1);
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // result check and output backpressure
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (crossing_q.size() == 0)
            begin
                errors <= errors + 1;
                $display("%0t: unexpected result edges_cross=%0b", $time, edges_cross);
            end
            else
            begin
                if (edges_cross !== crossing_q[0])
                begin
                    errors <= errors + 1;
                    $display("%0t: edges_cross expected %0b actual %0b",
                             $time, crossing_q[0], edges_cross);
                end
                n_hits    <= n_hits + int'(crossing_q[0]);
                n_results <= n_results + 1;
                void'(crossing_q.pop_front());
            end
        end
        if (cycles % 300 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 2);
            2: out_stall <= ($urandom_range(0, 9) < 6);
            default: out_stall <= ($urandom_range(0, 99) < 4) ? 1'b1
                                  : (out_stall && $urandom_range(0, 19) != 0);
        endcase
    end

    pair_row_t dir_rows [$];

    initial
    begin
        int unsigned tol_seq [5];
        errors     = 0;
        n_req      = 0;
        n_hits     = 0;
        n_results  = 0;
        cycles     = 0;
        stall_mode = 0;
        gaps_on    = 1'b1;
        tolerance  = '0;
        for (int k = 0; k <= 90; k++)
            sine_q14[k] = quarter_sine(k);

        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        first_center_x  <= '0;
        first_center_y  <= '0;
        first_width     <= '0;
        first_height    <= '0;
        first_angle     <= '0;
        second_center_x <= '0;
        second_center_y <= '0;
        second_width    <= '0;
        second_height   <= '0;
        second_angle    <= '0;
        out_stall       <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_data        <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset-value tolerance: directed rows with typed results where obvious
        dir_rows = '{
            '{mk_rect(0, 0, 0, 0, 0),        mk_rect(0, 0, 0, 0, 0),        0},
            '{mk_rect(0, 0, 160, 16, 0),     mk_rect(0, 0, 16, 160, 0),     1},
            '{mk_rect(0, 0, 160, 16, 45),    mk_rect(0, 0, 16, 160, 45),    1},
            '{mk_rect(0, 0, 160, 16, 90),    mk_rect(0, 0, 160, 16, 0),     1},
            '{mk_rect(0, 0, 320, 320, 0),    mk_rect(0, 0, 16, 16, 30),     0},
            '{mk_rect(0, 0, 100, 100, 10),   mk_rect(0, 0, 100, 100, 10),   0},
            '{mk_rect(-10000, 0, 50, 50, 0), mk_rect(10000, 0, 50, 50, 0),  0},
            '{mk_rect(0, 0, 100, 100, 0),    mk_rect(200, 0, 100, 100, 0),  0},
            '{mk_rect(0, 0, 0, 100, 0),      mk_rect(0, 0, 100, 0, 0),      -1},
            '{mk_rect(32767, 32767, 65535, 65535, 359),
              mk_rect(-32768, -32768, 65535, 65535, 511),                  -1},
            '{mk_rect(-32768, 32767, 65535, 0, 180),
              mk_rect(32767, -32768, 0, 65535, 270),                       -1},
            '{mk_rect(0, 0, 160, 16, 360),   mk_rect(0, 0, 16, 160, 0),     1},
            '{mk_rect(0, 0, 160, 16, 450),   mk_rect(0, 0, 160, 16, 0),     1},
            '{mk_rect(0, 0, 160, 16, 511),   mk_rect(5, 3, 16, 160, 359),   -1},
            '{mk_rect(0, 0, 200, 16, 89),    mk_rect(0, 0, 200, 16, 91),    -1},
            '{mk_rect(0, 0, 100, 50, 179),   mk_rect(30, 0, 100, 50, 181),  -1},
            '{mk_rect(0, 0, 100, 50, 269),   mk_rect(0, 30, 100, 50, 271),  -1},
            '{mk_rect(0, 0, 100, 100, 0),    mk_rect(100, 100, 100, 100, 0), -1},
            '{mk_rect(0, 0, 100, 100, 0),    mk_rect(0, 300, 100, 200, 0),  -1}
        };
        write_tolerance('0);
        foreach (dir_rows[i])
            send_pair(dir_rows[i].a, dir_rows[i].b, dir_rows[i].known);
        random_pairs(300);
        drain_pipe();

        tol_seq = '{255, 1, $urandom_range(2, 254), 128, 0};
        foreach (tol_seq[t])
        begin
            write_tolerance(TOL_BITS'(tol_seq[t]));
            foreach (dir_rows[i])
                if (dir_rows[i].known < 0)
                    send_pair(dir_rows[i].a, dir_rows[i].b, -1);
            random_pairs(340);
            drain_pipe();
        end

        $display("Checked %0d requests over six tolerance settings, %0d crossings seen.",
                 n_results, n_hits);
        $display("Stimulus mixed near, random and extreme rectangle pairs with gaps and stalls.");
        if (errors == 0 && crossing_q.size() == 0 && n_results == n_req)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== rotated_rect_edge_crossing.f =====
sv/rrec_pkg.sv
sv/rrec_corners.sv
sv/rrec_orient.sv
sv/rotated_rect_edge_crossing.sv
sv/rrec_checker.sv
bench/rotated_rect_edge_crossing_test.sv
